// ----- rtl/lafe_pkg.sv -----
`default_nettype none
package lafe_pkg;

   // action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_SET   = 2'd2;

   // triangle level range
   localparam int LEVEL_TOP = 100;
   localparam int LVL_MIN   = -128;
   localparam int LVL_MAX   = LEVEL_TOP + 127;
   localparam int LVL_W     = $clog2(LVL_MAX + 1) + 1;
   localparam int STEP_W    = 8;
   localparam int CH_W      = 8;
   localparam int MAG_W     = LVL_W - 1;

   // fade scaling: level * colour / LEVEL_TOP via reciprocal
   localparam int P_W     = MAG_W + CH_W;
   localparam int FADE_SH = P_W + 8;
   localparam logic [FADE_SH-1:0] RECIP = FADE_SH'((64'd1 << FADE_SH) / LEVEL_TOP);
   localparam logic [P_W+7:0] TOP_WIDE = (P_W + 8)'(LEVEL_TOP);

   typedef logic [3:0][CH_W-1:0] color_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now_ms;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  white;
      logic        blink_type;
      logic [30:0] duration_ms;
      logic [6:0]  frequency;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_white;
      logic       alert_active;
   } rsp_type;

   // evaluation result handed from the state logic to the fade pipeline
   typedef struct packed {
      logic             direct;
      logic             active;
      color_type        color;
      logic [LVL_W-1:0] level;
   } eval_type;

   typedef struct packed {
      logic      direct;
      logic      active;
      color_type color;
   } fade_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/lafe_core.sv -----
`default_nettype none
module lafe_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire lafe_pkg::req_type item,
   output lafe_pkg::eval_type     ev,
   output logic                   has_rsp
);
   import lafe_pkg::*;

   localparam logic signed [LVL_W:0] SAT_LO  = (LVL_W + 1)'(LVL_MIN);
   localparam logic signed [LVL_W:0] SAT_HI  = (LVL_W + 1)'(LVL_MAX);
   localparam logic signed [LVL_W-1:0] LV_ONE = LVL_W'(1);
   localparam logic signed [LVL_W-1:0] LV_TOP = LVL_W'(LEVEL_TOP);

   logic                running_ff, running_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [31:0]         start_ff, start_in;
   logic [30:0]         dur_ff, dur_in;
   logic                style_ff, style_in;
   color_type           acolor_ff, acolor_in;
   color_type           scolor_ff, scolor_in;

   color_type           req_color;
   logic                is_start;
   logic [31:0]         elapsed;
   logic                ended;
   logic signed [LVL_W:0]   diff;
   logic signed [LVL_W-1:0] lvl_new;
   logic signed [STEP_W-1:0] step_cur, step_new;
   logic                step_pos;

   assign req_color = {item.white, item.blue, item.green, item.red};
   assign is_start  = (item.action == ACT_START);

   always_comb begin
      // values in force for the evaluation (a start loads them first)
      acolor_in = is_start ? req_color : acolor_ff;
      style_in  = is_start ? item.blink_type : style_ff;
      start_in  = is_start ? item.now_ms : start_ff;
      step_cur  = is_start ? $signed({1'b0, item.frequency}) : $signed(step_ff);
      scolor_in = scolor_ff;
      dur_in    = is_start ? item.duration_ms : dur_ff;

      elapsed = item.now_ms - start_in;
      ended   = (elapsed >= {1'b0, dur_in});

      // triangle step with saturation
      diff = $signed({level_ff[LVL_W-1], level_ff}) -
             $signed({{(LVL_W + 1 - STEP_W){step_cur[STEP_W-1]}}, step_cur});
      if (diff < SAT_LO)
         lvl_new = LVL_W'(SAT_LO);
      else if (diff > SAT_HI)
         lvl_new = LVL_W'(SAT_HI);
      else
         lvl_new = diff[LVL_W-1:0];
      step_new = (lvl_new <= LV_ONE || lvl_new >= LV_TOP) ? -step_cur : step_cur;
      step_pos = (step_new > $signed(STEP_W'(0)));

      running_in = running_ff;
      level_in   = level_ff;
      step_in    = step_ff;
      has_rsp    = 1'b0;
      ev.direct  = 1'b1;
      ev.active  = 1'b0;
      ev.color   = scolor_ff;
      ev.level   = level_ff;

      case (item.action)
         ACT_TICK, ACT_START: begin
            if (is_start || running_ff) begin
               has_rsp = 1'b1;
               step_in = step_cur;
               if (ended) begin
                  running_in = 1'b0;
                  level_in   = LVL_W'(LEVEL_TOP);
               end else begin
                  running_in = 1'b1;
                  level_in   = lvl_new;
                  step_in    = step_new;
                  ev.active  = 1'b1;
                  ev.level   = lvl_new;
                  if (style_in) begin
                     ev.color = step_pos ? acolor_in : '0;
                  end else begin
                     ev.direct = 1'b0;
                     ev.color  = acolor_in;
                  end
               end
            end
         end
         ACT_SET: begin
            has_rsp   = 1'b1;
            scolor_in = req_color;
            ev.color  = req_color;
            ev.active = running_ff;
            if (running_ff)
               dur_in = '0;
         end
         default: begin
            // unused code: nothing changes
            acolor_in = acolor_ff;
            style_in  = style_ff;
            start_in  = start_ff;
            dur_in    = dur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         level_ff   <= LVL_W'(LEVEL_TOP);
         step_ff    <= '0;
         start_ff   <= '0;
         dur_ff     <= '0;
         style_ff   <= 1'b0;
         acolor_ff  <= '0;
         scolor_ff  <= '0;
      end else if (en) begin
         running_ff <= running_in;
         level_ff   <= level_in;
         step_ff    <= step_in;
         start_ff   <= start_in;
         dur_ff     <= dur_in;
         style_ff   <= style_in;
         acolor_ff  <= acolor_in;
         scolor_ff  <= scolor_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lafe_fade.sv -----
`default_nettype none
module lafe_fade (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_vld,
   input  wire lafe_pkg::eval_type in_eval,
   output logic                    out_vld,
   output lafe_pkg::rsp_type       out_rsp
);
   import lafe_pkg::*;

   logic                        s2_vld_ff;
   eval_type                    s2_ff;
   logic                        s3_vld_ff;
   fade_ctl_type                s3_ctl_ff;
   logic [3:0][P_W-1:0]         s3_prod_ff, s3_prod_in;
   logic                        s4_vld_ff;
   fade_ctl_type                s4_ctl_ff;
   logic [3:0][P_W-1:0]         s4_prod_ff;
   logic [3:0][P_W-1:0]         s4_quot_ff, s4_quot_in;

   logic [MAG_W-1:0]            mag;
   logic [3:0][P_W+FADE_SH-1:0] scaled;
   logic [3:0][P_W+7:0]         back, rem;
   logic [3:0][P_W-1:0]         fixed;
   color_type                   faded;

   // level magnitude, zero at or below zero
   assign mag = ($signed(s2_ff.level) <= $signed(LVL_W'(0))) ? '0 : s2_ff.level[MAG_W-1:0];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s3_prod_in[i] = {{CH_W{1'b0}}, mag} * {{MAG_W{1'b0}}, s2_ff.color[i]};
         scaled[i]     = {{FADE_SH{1'b0}}, s3_prod_ff[i]} * {{P_W{1'b0}}, RECIP};
         s4_quot_in[i] = scaled[i][FADE_SH +: P_W];
         // estimate is at most one low
         back[i]  = {8'd0, s4_quot_ff[i]} * TOP_WIDE;
         rem[i]   = {8'd0, s4_prod_ff[i]} - back[i];
         fixed[i] = s4_quot_ff[i] + P_W'(rem[i] >= TOP_WIDE);
         faded[i] = (fixed[i] > P_W'(255)) ? 8'hff : fixed[i][CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= in_vld;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff            <= in_eval;
         s3_ctl_ff.direct <= s2_ff.direct;
         s3_ctl_ff.active <= s2_ff.active;
         s3_ctl_ff.color  <= s2_ff.color;
         s3_prod_ff       <= s3_prod_in;
         s4_ctl_ff        <= s3_ctl_ff;
         s4_prod_ff       <= s3_prod_ff;
         s4_quot_ff       <= s4_quot_in;
      end
   end

   always_comb begin
      color_type c;
      c = s4_ctl_ff.direct ? s4_ctl_ff.color : faded;
      out_vld              = s4_vld_ff;
      out_rsp.out_red      = c[0];
      out_rsp.out_green    = c[1];
      out_rsp.out_blue     = c[2];
      out_rsp.out_white    = c[3];
      out_rsp.alert_active = s4_ctl_ff.active;
   end

endmodule
`default_nettype wire

// ----- rtl/led_alert_blink_fade_engine_unit.sv -----
`default_nettype none
// channel   | ports                               | moves
// ----------+-------------------------------------+-----------------------------
// request   | req_valid, req_ready, req_data      | one tick, start or set colour
// response  | rsp_valid, rsp_ready, rsp_data      | four drive levels and active
//
// one request per cycle sustained while no response is held; a response
// reaches the response register after its request is taken (input register,
// evaluation, fade product, reciprocal multiply, correction into the register)
// reset clears all alert state and the valid flags
// a held response freezes the whole pipeline; requests are still taken
// while the input register is empty
module led_alert_blink_fade_engine_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lafe_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lafe_pkg::rsp_type      rsp_data
);
   import lafe_pkg::*;

   // input register
   logic     s1_vld_ff;
   req_type  s1_ff;

   // response register
   logic     rsp_vld_ff;
   rsp_type  rsp_ff;

   logic     adv;
   eval_type ev;
   logic     has_rsp;
   logic     fade_vld;
   rsp_type  fade_rsp;

   // pipeline moves whenever the response slot is free or being emptied
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign req_ready = adv || !s1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready)
         s1_ff <= req_data;
   end

   // alert state and per-request evaluation
   lafe_core u_core (
      .clock   (clock),
      .reset   (reset),
      .en      (adv && s1_vld_ff),
      .item    (s1_ff),
      .ev      (ev),
      .has_rsp (has_rsp)
   );

   // fade scaling pipeline, direct colours ride alongside
   lafe_fade u_fade (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (s1_vld_ff && has_rsp),
      .in_eval (ev),
      .out_vld (fade_vld),
      .out_rsp (fade_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= fade_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv)
         rsp_ff <= fade_rsp;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
